@@ rtl/core/stsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Step-then-slew ramp package
// Shared types and constants for the setpoint ramp generator.
// ----------------------------------------------------------------------------
package stsr_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned STEP_W   = 31;
   localparam int unsigned ADDR_W   = 4;
   localparam int unsigned PDATA_W  = 32;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_PRESET = 1'b1
   } stsr_op_type;

   typedef enum logic [1:0] {
      REG_ACCEL_STEP     = 2'd0,
      REG_DECEL_STEP     = 2'd1,
      REG_RAMP_INCREMENT = 2'd2
   } stsr_reg_type;

   typedef struct packed {
      logic [STEP_W-1:0] accel_step;
      logic [STEP_W-1:0] decel_step;
      logic [STEP_W-1:0] ramp_increment;
   } stsr_cfg_type;

   typedef struct packed {
      logic        commit;
      stsr_op_type operation;
   } stsr_cmd_type;

endpackage

@@ rtl/core/stsr_if.sv @@
// ----------------------------------------------------------------------------
// Step-then-slew ramp channels
// Valid/ready channels for the item input and the result output.
// ----------------------------------------------------------------------------
interface stsr_req_if;
   import stsr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic signed [DATA_W-1:0]  value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface stsr_rsp_if;
   import stsr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  ramp_out;

   modport source (output valid, output ramp_out, input ready);
   modport sink   (input valid, input ramp_out, output ready);
endinterface

@@ rtl/core/stsr_csr.sv @@
// ----------------------------------------------------------------------------
// Step-then-slew ramp register file
// APB-style access to the jump and slew sizes.
// ----------------------------------------------------------------------------
module stsr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [stsr_pkg::ADDR_W-1:0]   paddr,
   input  logic [stsr_pkg::PDATA_W-1:0]  pwdata,
   output logic [stsr_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   output stsr_pkg::stsr_cfg_type        cfg
);
   import stsr_pkg::*;

   stsr_cfg_type cfg_ff;
   stsr_reg_type reg_sel;
   logic         wr_en;

   assign reg_sel = stsr_reg_type'(paddr[3:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_ACCEL_STEP:     cfg_ff.accel_step     <= pwdata[STEP_W-1:0];
            REG_DECEL_STEP:     cfg_ff.decel_step     <= pwdata[STEP_W-1:0];
            REG_RAMP_INCREMENT: cfg_ff.ramp_increment <= pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_ACCEL_STEP:     prdata = {1'b0, cfg_ff.accel_step};
         REG_DECEL_STEP:     prdata = {1'b0, cfg_ff.decel_step};
         REG_RAMP_INCREMENT: prdata = {1'b0, cfg_ff.ramp_increment};
         default:            prdata = '0;
      endcase
   end

endmodule

@@ rtl/core/stsr_ramp_core.sv @@
// ----------------------------------------------------------------------------
// Step-then-slew ramp core
// Holds the ramp state and works out the next ramp value for one item.
// ----------------------------------------------------------------------------
module stsr_ramp_core (
   input  logic                              clock,
   input  logic                              reset,
   input  stsr_pkg::stsr_cmd_type            cmd,
   input  logic signed [stsr_pkg::DATA_W-1:0] value,
   input  stsr_pkg::stsr_cfg_type            cfg,
   output logic signed [stsr_pkg::DATA_W-1:0] ramp_next
);
   import stsr_pkg::*;

   logic signed [DATA_W-1:0] ramp_ff;
   logic signed [DATA_W-1:0] target_ff;
   logic                     jump_done_ff;

   logic                     jump_pending;
   logic                     same_sign;
   logic                     dir_up;
   logic [STEP_W-1:0]        jump_size;
   logic [DATA_W-1:0]        amount;
   logic signed [DATA_W+1:0] ramp_wide;
   logic signed [DATA_W+1:0] value_wide;
   logic signed [DATA_W+1:0] sum_up;
   logic signed [DATA_W+1:0] sum_down;
   logic signed [DATA_W-1:0] moved;

   // The jump and the slew go the same way and both clamp at the target, so
   // they fold into a single move by their combined size.
   assign jump_pending = ~jump_done_ff | (value != target_ff);
   assign same_sign    = (ramp_ff == '0) | ((ramp_ff > 0) == (value > 0));
   assign jump_size    = same_sign ? cfg.accel_step : cfg.decel_step;
   assign amount       = {1'b0, cfg.ramp_increment}
                       + (jump_pending ? {1'b0, jump_size} : '0);
   assign dir_up       = value > ramp_ff;

   assign ramp_wide  = {{2{ramp_ff[DATA_W-1]}}, ramp_ff};
   assign value_wide = {{2{value[DATA_W-1]}}, value};
   assign sum_up     = ramp_wide + $signed({2'b00, amount});
   assign sum_down   = ramp_wide - $signed({2'b00, amount});

   always_comb begin
      if (dir_up) begin
         moved = (sum_up >= value_wide) ? value : sum_up[DATA_W-1:0];
      end else begin
         moved = (sum_down <= value_wide) ? value : sum_down[DATA_W-1:0];
      end
   end

   assign ramp_next = (cmd.operation == OP_PRESET) ? value : moved;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff      <= '0;
         target_ff    <= '0;
         jump_done_ff <= 1'b0;
      end else if (cmd.commit) begin
         ramp_ff      <= ramp_next;
         target_ff    <= value;
         jump_done_ff <= (cmd.operation == OP_UPDATE);
      end
   end

`ifndef SYNTHESIS
   a_jump_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> jump_done_ff == ($past(cmd.operation) == OP_UPDATE))
      else $error("jump flag does not follow the committed operation");

   a_no_overshoot_up: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && cmd.operation == OP_UPDATE && value > ramp_ff)
      |=> (ramp_ff <= $past(value)) && (ramp_ff >= $past(ramp_ff)))
      else $error("upward move left the span between ramp and target");

   a_no_overshoot_down: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && cmd.operation == OP_UPDATE && value <= ramp_ff)
      |=> (ramp_ff >= $past(value)) && (ramp_ff <= $past(ramp_ff)))
      else $error("downward move left the span between ramp and target");
`endif

endmodule

@@ rtl/core/step_then_slew_ramp.sv @@
// ----------------------------------------------------------------------------
// Step-then-slew setpoint ramp generator
// Jumps once toward a new target, then slews toward it by a fixed increment.
// ----------------------------------------------------------------------------
// Items arrive on the req channel: an update carries a target, a preset loads
// the ramp value directly. Every item gives exactly one beat on the rsp
// channel, holding the ramp value after that item, in signed Q16.16.
// The jump sizes and the slew increment are set over the APB-style port at
// byte addresses 0, 4 and 8, and are meant to be written while no item is in
// flight. A beat accepted into the input register is worked on from there,
// and its result is offered from the output register. One beat is accepted
// in every cycle unless both registers are full and the receiver stalls;
// the ramp state is read and updated as an item passes between the two
// registers, so back-to-back updates each see the previous result.
// When the receiver stalls, the result waits in the output register, the
// next item waits in the input register, and req is held off only once both
// are full. A synchronous reset empties both registers, clears the ramp, the
// remembered target and the jump and slew sizes, and leaves a jump pending.
// ----------------------------------------------------------------------------
module step_then_slew_ramp (
   input  logic                          clock,
   input  logic                          reset,
   stsr_req_if.sink                      req_bus,
   stsr_rsp_if.source                    rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [stsr_pkg::ADDR_W-1:0]   paddr,
   input  logic [stsr_pkg::PDATA_W-1:0]  pwdata,
   output logic [stsr_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready
);
   import stsr_pkg::*;

   stsr_cfg_type             cfg;
   stsr_cmd_type             cmd;

   // Input register: one accepted beat waiting for the ramp core.
   logic                     in_valid_ff;
   stsr_op_type              in_op_ff;
   logic signed [DATA_W-1:0] in_value_ff;

   // Output register: the result beat offered to the receiver.
   logic                     out_valid_ff;
   logic signed [DATA_W-1:0] out_ramp_ff;

   logic                     out_load;
   logic                     in_load;
   logic signed [DATA_W-1:0] ramp_next;

   // The output register can take a new result when it is empty or its
   // current beat leaves in this cycle; the input register refills when it is
   // empty or when the output register can take its beat.
   assign out_load = ~out_valid_ff | rsp_bus.ready;
   assign in_load  = ~in_valid_ff | out_load;

   assign req_bus.ready    = in_load;
   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.ramp_out = out_ramp_ff;

   // The state moves on exactly when an item passes to the output register.
   assign cmd.commit    = in_valid_ff & out_load;
   assign cmd.operation = in_op_ff;

   stsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   stsr_ramp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .value     (in_value_ff),
      .cfg       (cfg),
      .ramp_next (ramp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= req_bus.valid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (in_load && req_bus.valid) begin
         in_op_ff    <= stsr_op_type'(req_bus.operation);
         in_value_ff <= req_bus.value;
      end
      if (cmd.commit) begin
         out_ramp_ff <= ramp_next;
      end
   end

`ifndef SYNTHESIS
   a_preset_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && in_op_ff == OP_PRESET) |=> out_ramp_ff == $past(in_value_ff))
      else $error("preset result differs from the loaded value");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_load) |=> in_valid_ff && $stable(in_value_ff)
                                     && $stable(in_op_ff))
      else $error("input register changed while the output was stalled");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> out_valid_ff)
      else $error("committed item produced no result beat");
`endif

endmodule
